// ----- sv/fbpa_pkg.sv -----
package fbpa_pkg;

   localparam int OFFSET_W = 32;
   localparam int CHUNK_W  = 24;
   localparam int COUNT_W  = 9;

   localparam logic [7:0] CSR_SLOT_COUNT   = 8'd0;
   localparam logic [7:0] CSR_CHUNK_LENGTH = 8'd1;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET   = 9'd256;
   localparam logic [CHUNK_W-1:0] CHUNK_LENGTH_RESET = 24'd1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_EXHAUSTED = 3'd1,
      ST_NULL      = 3'd2,
      ST_RANGE     = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_DIV,
      S_FREE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                   done;
      logic [OFFSET_W-1:0]    quotient;
   } div_stat_type;

   typedef struct packed {
      logic                   rd;
      logic                   pop;
      logic                   push;
      logic [COUNT_W-1:0]     push_slot;
   } stk_ctrl_type;

   typedef struct packed {
      logic [COUNT_W-1:0]     top;
      logic [COUNT_W-1:0]     rd_slot;
   } stk_stat_type;

endpackage

// ----- sv/fbpa_divider.sv -----
module fbpa_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbpa_pkg::OFFSET_W-1:0] dividend,
   input  logic [fbpa_pkg::CHUNK_W-1:0]  divisor,
   output fbpa_pkg::div_stat_type        stat
);
   import fbpa_pkg::*;

   localparam logic [5:0] STEPS = 6'd32;

   logic [5:0]          count_ff, count_in;
   logic                busy_ff, busy_in;
   logic [CHUNK_W-1:0]  rem_ff, rem_in;
   logic [OFFSET_W-1:0] quo_ff, quo_in;
   logic [CHUNK_W:0]    trial;
   logic [CHUNK_W:0]    diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, quo_ff[OFFSET_W-1]};
      diff     = trial - {1'b0, divisor};
      count_in = count_ff;
      busy_in  = busy_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = STEPS;
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         if (count_ff != 6'd0) begin
            if (!diff[CHUNK_W]) begin
               rem_in = diff[CHUNK_W-1:0];
               quo_in = {quo_ff[OFFSET_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CHUNK_W-1:0];
               quo_in = {quo_ff[OFFSET_W-2:0], 1'b0};
            end
            count_in = count_ff - 6'd1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.done     = busy_ff && (count_ff == 6'd0);
   assign stat.quotient = quo_ff;

endmodule

// ----- sv/fbpa_stack.sv -----
module fbpa_stack #(
   parameter int DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fbpa_pkg::stk_ctrl_type ctrl,
   output fbpa_pkg::stk_stat_type stat
);
   import fbpa_pkg::*;

   localparam int ENTRY_W = $clog2(DEPTH);

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [COUNT_W-1:0] top_ff, top_in;
   // entries at or above the high-water mark were never written; a read there returns its own index
   logic [COUNT_W-1:0] hw_ff, hw_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] rd_addr_ff;
   logic               fresh_ff;
   logic [COUNT_W-1:0] push_top;

   assign push_top = top_ff - 9'd1;

   always_comb begin
      top_in = top_ff;
      hw_in  = hw_ff;
      if (ctrl.pop) begin
         top_in = top_ff + 9'd1;
         if (top_ff == hw_ff) begin
            hw_in = hw_ff + 9'd1;
         end
      end else if (ctrl.push) begin
         top_in = push_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         hw_ff  <= '0;
      end else begin
         top_ff <= top_in;
         hw_ff  <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         rd_data_ff <= mem[top_ff[ENTRY_W-1:0]];
         rd_addr_ff <= top_ff[ENTRY_W-1:0];
         fresh_ff   <= (top_ff >= hw_ff);
      end
      if (ctrl.push) begin
         mem[push_top[ENTRY_W-1:0]] <= ctrl.push_slot[ENTRY_W-1:0];
      end
   end

   assign stat.top     = top_ff;
   assign stat.rd_slot = fresh_ff ? COUNT_W'(rd_addr_ff) : COUNT_W'(rd_data_ff);

endmodule

// ----- sv/fixed_block_pool_allocator_core.sv -----
// Fixed-size block pool allocator: stack of free slots plus an iterative divider.
// Path to rsp_tvalid: allocate via S_READ, S_MUL and S_OUT; exhausted or null free via
// S_OUT; negative-offset free via S_FREE and S_OUT; other frees via S_DIV (32 divider
// steps), S_FREE and S_OUT. One request at a time: a new one is taken only in S_IDLE.
// Synchronous active-high reset refills the stack (slots 0,1,2,... free) without
// a clearing pass, sets slot_count to 256 and chunk_length to 1.
module fixed_block_pool_allocator_core #(
   parameter int MAX_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] release_offset, [32] release_is_null
   input  logic [0:0]  req_tuser,   // [0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] grant_offset, [39:32] slot_number,
                                    // [48:40] slots_in_use
   output logic [2:0]  rsp_tuser,   // [2:0] status
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [fbpa_pkg::CHUNK_W-1:0] csr_data
);
   import fbpa_pkg::*;

   // slot numbers never reach 511 since slot_count is nine bits wide
   localparam int CAP   = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
   localparam int DEPTH = (MAX_SLOTS > 512) ? 512 : MAX_SLOTS;

   // configuration registers
   logic [COUNT_W-1:0] slot_count_ff, slot_count_in;
   logic [CHUNK_W-1:0] chunk_length_ff, chunk_length_in;
   logic [COUNT_W-1:0] n_eff;
   logic [CHUNK_W-1:0] chunk_eff;

   // sequencer and working registers
   state_type          state_ff, state_in;
   status_type         res_status_ff, res_status_in;
   logic [COUNT_W-1:0] slot_ff, slot_in;
   logic [31:0]        grant_ff, grant_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               in_range_ff, in_range_in;

   // result output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [55:0]        rsp_data_ff, rsp_data_in;
   logic [2:0]         rsp_user_ff, rsp_user_in;

   logic               accept;
   logic               div_start;
   logic [31:0]        mag;
   logic [32:0]        prod;
   div_stat_type       div_stat;
   stk_ctrl_type       stk_ctrl;
   stk_stat_type       stk_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      slot_count_in   = slot_count_ff;
      chunk_length_in = chunk_length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SLOT_COUNT:   slot_count_in   = csr_data[COUNT_W-1:0];
            CSR_CHUNK_LENGTH: chunk_length_in = csr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff   <= SLOT_COUNT_RESET;
         chunk_length_ff <= CHUNK_LENGTH_RESET;
      end else begin
         slot_count_ff   <= slot_count_in;
         chunk_length_ff <= chunk_length_in;
      end
   end

   // saturate the pool size, treat a zero chunk length as one
   assign n_eff     = (slot_count_ff > COUNT_W'(CAP)) ? COUNT_W'(CAP) : slot_count_ff;
   assign chunk_eff = (chunk_length_ff == '0) ? CHUNK_W'(1) : chunk_length_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign mag        = 32'd0 - req_tdata[31:0];
   assign prod       = 33'(slot_ff) * 33'(chunk_eff);

   fbpa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[31:0]),
      .divisor  (chunk_eff),
      .stat     (div_stat)
   );

   fbpa_stack #(
      .DEPTH (DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .ctrl  (stk_ctrl),
      .stat  (stk_stat)
   );

   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      slot_in       = slot_ff;
      grant_in      = grant_ff;
      idx_in        = idx_ff;
      in_range_in   = in_range_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      div_start     = 1'b0;
      stk_ctrl      = '0;

      case (state_ff)
         S_IDLE: begin
            // read the top entry ahead so a pop finds its data ready
            stk_ctrl.rd = 1'b1;
            if (accept) begin
               slot_in  = '0;
               grant_in = '0;
               if (req_tuser[0] == KIND_ALLOC) begin
                  if (stk_stat.top >= n_eff) begin
                     res_status_in = ST_EXHAUSTED;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_READ;
                  end
               end else if (req_tdata[32]) begin
                  res_status_in = ST_NULL;
                  state_in      = S_OUT;
               end else if (req_tdata[31]) begin
                  // negative offsets decode to slot 0 when within one chunk
                  idx_in      = '0;
                  in_range_in = (mag < {8'd0, chunk_eff}) && (n_eff != '0);
                  state_in    = S_FREE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_READ: begin
            stk_ctrl.pop = 1'b1;
            slot_in      = stk_stat.rd_slot;
            state_in     = S_MUL;
         end
         S_MUL: begin
            grant_in      = prod[31:0];
            res_status_in = ST_GRANTED;
            state_in      = S_OUT;
         end
         S_DIV: begin
            if (div_stat.done) begin
               idx_in      = div_stat.quotient[COUNT_W-1:0];
               in_range_in = div_stat.quotient < 32'(n_eff);
               state_in    = S_FREE;
            end
         end
         S_FREE: begin
            // check order: range first, then an empty pool
            if (!in_range_ff) begin
               res_status_in = ST_RANGE;
            end else if (stk_stat.top == '0) begin
               res_status_in = ST_EMPTY;
            end else begin
               stk_ctrl.push      = 1'b1;
               stk_ctrl.push_slot = idx_ff;
               slot_in            = idx_ff;
               res_status_in      = ST_GRANTED;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, stk_stat.top, slot_ff[7:0], grant_ff};
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      slot_ff       <= slot_in;
      grant_ff      <= grant_in;
      idx_ff        <= idx_in;
      in_range_ff   <= in_range_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
